[design/crfq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfq_pkg: shared types and constants for the CAN receive frame queue
// Beat structs for the request and response channels, queue sizing and the
// byte-keep mask helper.
// ----------------------------------------------------------------------------
package crfq_pkg;

	// Queue sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Frame field sizes
	localparam int ID_W        = 29;
	localparam int IDENT_W     = ID_W + 1;
	localparam int STD_ID_W    = 11;
	localparam int DATA_W      = 64;
	localparam int LEN_W       = 4;
	localparam int MAX_BYTES   = 8;

	localparam logic [4:0] ID_BITS_NONE = 5'd0;
	localparam logic [4:0] ID_BITS_STD  = 5'd11;
	localparam logic [4:0] ID_BITS_EXT  = 5'd29;

	// Request opcodes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] rx_ident_word;
		logic [3:0]  rx_dlc;
		logic [31:0] rx_data_low;
		logic [31:0] rx_data_high;
		logic [3:0]  pop_max_len;
	} req_t;

	typedef struct packed {
		logic [28:0] out_id;
		logic [4:0]  out_id_bits;
		logic [31:0] out_data_low;
		logic [31:0] out_data_high;
		logic [3:0]  out_length;
		logic        dropped;
		logic [4:0]  fill_level;
		logic [3:0]  head_length;
	} rsp_t;

	// Keep the first len bytes (len 0..8) of a little-endian payload
	function automatic logic [DATA_W-1:0] keep_mask(input logic [LEN_W-1:0] len);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < MAX_BYTES; b++) begin
			if (len > LEN_W'(b)) begin
				m[8*b +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

[design/can_rx_frame_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rx_frame_queue: ring-buffer receive queue for CAN frames
// Push decodes the mailbox identifier word, clamps the length code to eight
// and stores the frame if there is room; pop returns the oldest frame with
// its length clamped to the reader's limit. Every beat gets one response.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   req (req_t)
//  rsp      out        rsp_valid / rsp_stall   rsp (rsp_t)
//
//  Two register stages: the decision, pointer update and slot read happen at
//  the accept edge, the response is formed from the slot read and registered
//  in the output register. One beat per cycle when rsp is not stalled.
//  Reset clears pointers, fill count and valid flags; slot contents are not
//  cleared (never read before written). A stalled response holds both stages
//  and raises req_stall in the same cycle.
// ----------------------------------------------------------------------------
module can_rx_frame_queue
	import crfq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Slot storage
	logic [IDENT_W-1:0] slot_ident  [QUEUE_DEPTH];
	logic [DATA_W-1:0]  slot_data   [QUEUE_DEPTH];
	logic [LEN_W-1:0]   slot_length [QUEUE_DEPTH];

	// Ring state
	logic [PTR_W-1:0] rp_q, wp_q;
	logic [CNT_W-1:0] cnt_q;

	// Stage 1 registers
	logic               vld_s1;
	logic               pop_s1;
	logic               drop_s1;
	logic [LEN_W-1:0]   maxlen_s1;
	logic [CNT_W-1:0]   cnt_s1;
	logic               byp_s1;
	logic [LEN_W-1:0]   len_new_s1;
	logic [IDENT_W-1:0] ident_rd_s1;
	logic [DATA_W-1:0]  data_rd_s1;
	logic [LEN_W-1:0]   len_rd_s1;
	logic [LEN_W-1:0]   head_rd_s1;

	// Output register
	logic rsp_vld_q;
	rsp_t rsp_q;

	logic               adv;
	logic               acc;
	logic               empty, full;
	logic               push_ok, pop_ok, drop;
	logic [PTR_W-1:0]   rp_nx, wp_inc, rp_inc;
	logic [CNT_W-1:0]   cnt_nx;
	logic [LEN_W-1:0]   len_in;
	logic [IDENT_W-1:0] ident_in;
	logic [DATA_W-1:0]  data_in;

	// Handshake: both stages move together unless the response is held
	assign adv       = !(rsp_vld_q && rsp_stall);
	assign req_stall = !adv;
	assign acc       = req_valid && adv;

	// Push/pop decision from the current fill count
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign push_ok = acc && (req.mode == MODE_PUSH) && !full;
	assign drop    = acc && (req.mode == MODE_PUSH) && full;
	assign pop_ok  = acc && (req.mode == MODE_POP) && !empty;

	assign wp_inc = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign rp_nx  = pop_ok ? rp_inc : rp_q;

	always_comb begin
		cnt_nx = cnt_q;
		if (push_ok) begin
			cnt_nx = cnt_q + 1'b1;
		end else if (pop_ok) begin
			cnt_nx = cnt_q - 1'b1;
		end
	end

	// Frame decode: clamp length, pick extended or standard id, zero spare bytes
	assign len_in   = (req.rx_dlc > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : req.rx_dlc;
	assign ident_in = req.rx_ident_word[2] ? {1'b1, req.rx_ident_word[31:3]}
		: {{(IDENT_W - STD_ID_W){1'b0}}, req.rx_ident_word[31:21]};
	assign data_in  = {req.rx_data_high, req.rx_data_low} & keep_mask(len_in);

	// Ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wp_q <= wp_inc;
			end
			rp_q  <= rp_nx;
			cnt_q <= cnt_nx;
		end
	end

	// Slot memory: one write port, reads registered at the accept edge
	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_ident[wp_q]  <= ident_in;
			slot_data[wp_q]   <= data_in;
			slot_length[wp_q] <= len_in;
		end
		if (adv) begin
			ident_rd_s1 <= slot_ident[rp_q];
			data_rd_s1  <= slot_data[rp_q];
			len_rd_s1   <= slot_length[rp_q];
			head_rd_s1  <= slot_length[rp_nx];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pop_s1     <= pop_ok;
			drop_s1    <= drop;
			maxlen_s1  <= req.pop_max_len;
			cnt_s1     <= cnt_nx;
			// push into an empty queue: new head is the frame being written
			byp_s1     <= push_ok && empty;
			len_new_s1 <= len_in;
		end
	end

	// Response forming
	logic [LEN_W-1:0]  plen;
	logic [DATA_W-1:0] pdata;
	rsp_t              rsp_d;

	assign plen  = (maxlen_s1 < len_rd_s1) ? maxlen_s1 : len_rd_s1;
	assign pdata = data_rd_s1 & keep_mask(plen);

	always_comb begin
		rsp_d = '0;
		if (pop_s1) begin
			rsp_d.out_id        = ident_rd_s1[ID_W-1:0];
			rsp_d.out_id_bits   = ident_rd_s1[ID_W] ? ID_BITS_EXT : ID_BITS_STD;
			rsp_d.out_data_low  = pdata[31:0];
			rsp_d.out_data_high = pdata[63:32];
			rsp_d.out_length    = plen;
		end else begin
			rsp_d.out_id_bits = ID_BITS_NONE;
		end
		rsp_d.dropped    = drop_s1;
		rsp_d.fill_level = 5'(cnt_s1);
		if (cnt_s1 == '0) begin
			rsp_d.head_length = '0;
		end else if (byp_s1) begin
			rsp_d.head_length = len_new_s1;
		end else begin
			rsp_d.head_length = head_rd_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// Checks
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wp_q == rp_q))
		else $error("empty queue with unequal pointers");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.dropped) |-> (rsp.fill_level == 5'(QUEUE_DEPTH)))
		else $error("drop reported while queue not full");

	a_len_id: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.out_length != '0) |-> (rsp.out_id_bits != ID_BITS_NONE))
		else $error("data delivered without a popped frame");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.fill_level == '0) |-> (rsp.head_length == '0))
		else $error("head length nonzero on empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (cnt_q <= CNT_W'(QUEUE_DEPTH)))
		else $error("fill count beyond queue depth");

endmodule

[dv/tb_can_rx_frame_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_rx_frame_queue: self-checking bench for the CAN receive frame queue
// A clocked driver sends push/pop beats from a pending list and a clocked
// monitor checks every response against a ring-buffer predictor kept in the
// bench. Both sides insert random gaps, with some stretches of back-to-back
// traffic. Stimulus is a short directed set followed by random push, pop and
// mixed bursts that fill, overflow and drain the queue.
// ----------------------------------------------------------------------------
module tb_can_rx_frame_queue;
	import crfq_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1000;
	localparam int MAX_WAIT    = 16;
	localparam int TAIL_CYCLES = 8;

	// one pending beat; drain_first holds it back until all responses are in
	typedef struct {
		req_t beat;
		bit   drain_first;
	} stim_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	can_rx_frame_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// predictor copy of the frame ring
	logic [IDENT_W-1:0] ring_ident [QUEUE_DEPTH];
	logic [DATA_W-1:0]  ring_data  [QUEUE_DEPTH];
	logic [LEN_W-1:0]   ring_len   [QUEUE_DEPTH];
	int unsigned ring_rd    = 0;
	int unsigned ring_wr    = 0;
	int unsigned ring_level = 0;

	stim_t beats_pending[$];
	rsp_t  frames_due[$];
	int unsigned beats_queued = 0;
	int unsigned beats_sent   = 0;
	int unsigned mismatches   = 0;
	int unsigned cycles       = 0;
	int unsigned send_gap     = 0;
	int unsigned recv_gap     = 0;
	bit calm = 1'b0;

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	function automatic int unsigned pick_wait();
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// little-endian payload trimmed to n bytes
	function automatic logic [DATA_W-1:0] first_bytes(logic [DATA_W-1:0] d, int unsigned n);
		if (n >= MAX_BYTES)
			return d;
		return d & ((64'd1 << (8 * n)) - 64'd1);
	endfunction

	// advance the predicted ring by one beat and return the expected response
	function automatic rsp_t ring_step(req_t b);
		rsp_t r;
		int unsigned n;
		r = '0;
		if (b.mode == MODE_PUSH) begin
			if (ring_level >= QUEUE_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				n = (b.rx_dlc > MAX_BYTES) ? MAX_BYTES : b.rx_dlc;
				if (b.rx_ident_word[2]) begin
					ring_ident[ring_wr] = {1'b1, b.rx_ident_word[31:3]};
				end else begin
					ring_ident[ring_wr] = {1'b0, 18'd0, b.rx_ident_word[31:21]};
				end
				ring_data[ring_wr] = first_bytes({b.rx_data_high, b.rx_data_low}, n);
				ring_len[ring_wr]  = LEN_W'(n);
				ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
				ring_level++;
			end
		end else if (ring_level > 0) begin
			n = (b.pop_max_len < ring_len[ring_rd]) ? b.pop_max_len : ring_len[ring_rd];
			r.out_id      = ring_ident[ring_rd][ID_W-1:0];
			r.out_id_bits = ring_ident[ring_rd][ID_W] ? ID_BITS_EXT : ID_BITS_STD;
			{r.out_data_high, r.out_data_low} = first_bytes(ring_data[ring_rd], n);
			r.out_length  = LEN_W'(n);
			ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
			ring_level--;
		end
		r.fill_level  = 5'(ring_level);
		r.head_length = (ring_level > 0) ? ring_len[ring_rd] : '0;
		return r;
	endfunction

	function automatic bit field_bad(string name, logic [31:0] want, logic [31:0] got);
		if (got === want)
			return 1'b0;
		$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
		return 1'b1;
	endfunction

	task automatic add_push(logic [31:0] word, logic [3:0] dlc, logic [31:0] lo,
			logic [31:0] hi, bit drain);
		stim_t s;
		s.beat.mode          = MODE_PUSH;
		s.beat.rx_ident_word = word;
		s.beat.rx_dlc        = dlc;
		s.beat.rx_data_low   = lo;
		s.beat.rx_data_high  = hi;
		s.beat.pop_max_len   = 4'($urandom_range(0, 15));
		s.drain_first        = drain;
		beats_pending.push_back(s);
	endtask

	// unused push fields are randomized on pops too
	task automatic add_pop(logic [3:0] max_len, bit drain);
		stim_t s;
		s.beat.mode          = MODE_POP;
		s.beat.rx_ident_word = $urandom;
		s.beat.rx_dlc        = 4'($urandom_range(0, 15));
		s.beat.rx_data_low   = $urandom;
		s.beat.rx_data_high  = $urandom;
		s.beat.pop_max_len   = max_len;
		s.drain_first        = drain;
		beats_pending.push_back(s);
	endtask

	// request driver: predicts on each accepted beat, then presents the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap  <= 0;
		end else begin
			stim_t nxt;
			if (req_valid && !req_stall) begin
				frames_due.push_back(ring_step(req));
				beats_sent++;
				if (beats_sent % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
			end
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap  <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (beats_pending.size() == 0) begin
					req_valid <= 1'b0;
				end else if (beats_pending[0].drain_first && frames_due.size() != 0) begin
					req_valid <= 1'b0;
				end else begin
					nxt = beats_pending.pop_front();
					req       <= nxt.beat;
					req_valid <= 1'b1;
					send_gap  <= pick_wait();
				end
			end
		end
	end

	// response monitor: random stall, compare each beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			recv_gap  <= 0;
		end else begin
			rsp_t want;
			bit bad;
			int unsigned w;
			if (rsp_valid && !rsp_stall) begin
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected response, expected none actual 0x%0h", $time, rsp);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					bad  = 1'b0;
					bad |= field_bad("out_id", 32'(want.out_id), 32'(rsp.out_id));
					bad |= field_bad("out_id_bits", 32'(want.out_id_bits), 32'(rsp.out_id_bits));
					bad |= field_bad("out_data_low", want.out_data_low, rsp.out_data_low);
					bad |= field_bad("out_data_high", want.out_data_high, rsp.out_data_high);
					bad |= field_bad("out_length", 32'(want.out_length), 32'(rsp.out_length));
					bad |= field_bad("dropped", 32'(want.dropped), 32'(rsp.dropped));
					bad |= field_bad("fill_level", 32'(want.fill_level), 32'(rsp.fill_level));
					bad |= field_bad("head_length", 32'(want.head_length), 32'(rsp.head_length));
					if (bad)
						mismatches++;
				end
				w = pick_wait();
				recv_gap  <= w;
				rsp_stall <= (w != 0);
			end else if (recv_gap > 0) begin
				recv_gap  <= recv_gap - 1;
				rsp_stall <= (recv_gap > 1);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned kind;
		int unsigned burst;
		bit drain;
		bit first_burst;
		bit is_push;

		// directed: empty pops, id extremes, length clamp, reader limits
		add_pop(4'hF, 1'b0);
		add_push(32'hFFFF_FFFB, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_push(32'hFFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_push(32'h0000_0000, 4'd0, $urandom, $urandom, 1'b0);
		add_push(32'h0000_0004, 4'd3, $urandom, $urandom, 1'b0);
		add_push($urandom, 4'd9, $urandom, $urandom, 1'b0);
		add_pop(4'hF, 1'b0);
		add_pop(4'h0, 1'b0);
		add_pop(4'h8, 1'b0);
		add_pop(4'hF, 1'b0);
		add_pop(4'h5, 1'b0);
		add_pop(4'hF, 1'b0);
		add_pop(4'h0, 1'b0);

		// random bursts: push runs overflow the ring, pop runs drain past empty
		first_burst = 1'b1;
		while (beats_pending.size() < ITEM_TARGET) begin
			kind  = $urandom_range(0, 9);
			burst = $urandom_range(1, 20);
			drain = first_burst || ($urandom_range(0, 15) == 0);
			first_burst = 1'b0;
			for (int i = 0; i < burst; i++) begin
				if (kind < 4)
					is_push = 1'b1;
				else if (kind < 7)
					is_push = 1'b0;
				else
					is_push = $urandom_range(0, 1);
				if (is_push)
					add_push($urandom, 4'($urandom_range(0, 15)), $urandom, $urandom, drain);
				else
					add_pop(4'($urandom_range(0, 15)), drain);
				drain = 1'b0;
			end
		end
		beats_queued = beats_pending.size();

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		while (beats_sent < beats_queued) @(negedge clk);
		while (frames_due.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
design/crfq_pkg.sv
design/can_rx_frame_queue.sv
dv/tb_can_rx_frame_queue.sv
